// File: hdl/four_channel_press_rate_meter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the press rate meter core
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_PRESS_RATE_METER_CORE_DEFINES_SVH
`define FOUR_CHANNEL_PRESS_RATE_METER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset.
`define FCPRM_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("fcprm: same-cycle check failed");
// Next-cycle implication, disabled in reset.
`define FCPRM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("fcprm: next-cycle check failed");
`else
`define FCPRM_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define FCPRM_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// File: hdl/fcprm_pkg.sv
// ----------------------------------------------------------------------------
// Press rate meter package
// Widths, fixed-point constants and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package fcprm_pkg;

   // Channel and field widths.
   localparam int CHANNELS      = 4;
   localparam int CH_BITS       = 2;
   localparam int TIME_BITS     = 32;
   localparam int FRACTION_BITS = 8;
   localparam int RATE_BITS     = 18;
   localparam int COUNT_BITS    = 32;
   localparam int AVG_BITS      = 24;

   // Divider and product widths.
   localparam int QUOT_BITS  = AVG_BITS;
   localparam int PROD_BITS  = COUNT_BITS + RATE_BITS;
   localparam int SAT_BITS   = TIME_BITS + QUOT_BITS;
   localparam int STEP_BITS  = $clog2(QUOT_BITS + 1);

   // One second in milliseconds, scaled to the rate fraction.
   localparam logic [RATE_BITS-1:0] SCALE   = RATE_BITS'(1000 << FRACTION_BITS);
   localparam logic [AVG_BITS-1:0]  AVG_MAX = {AVG_BITS{1'b1}};

   // Operation codes.
   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef logic [CH_BITS-1:0] ch_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic   load;
      logic   prep;
      logic   div_start;
      logic   commit;
      logic   finish;
      logic   emit;
      logic   last;
      ch_type ch;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

// File: hdl/four_channel_press_rate_meter_core.sv
// ----------------------------------------------------------------------------
// Four-channel press rate meter
// Rising-edge counter and instant/average rate meter for four buttons.
// ----------------------------------------------------------------------------
// One item is handled at a time. Each channel whose sample sees a press at
// a nonzero interval, or whose restart average has to be divided, also
// passes through the single shared restoring divider, which produces one
// quotient bit per clock. The four reports leave in channel order through
// one output register, which may hold the final report while the next
// item is taken in.
module four_channel_press_rate_meter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [31:0] req_time_ms,
   input  logic        req_button_a,
   input  logic        req_button_b,
   input  logic        req_button_x,
   input  logic        req_button_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_channel,
   output logic [17:0] rsp_instant_rate,
   output logic [31:0] rsp_press_count,
   output logic [23:0] rsp_average_rate,
   output logic [31:0] rsp_elapsed_ms,
   output logic        rsp_last_report
);
   import fcprm_pkg::*;

   cmd_type             cmd;
   stat_type            stat;
   logic [CHANNELS-1:0] levels;

   // Channel 0 in the low bit.
   assign levels = {req_button_y, req_button_x, req_button_b, req_button_a};

   fcprm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   fcprm_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_time_ms      (req_time_ms),
      .req_levels       (levels),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel      (rsp_channel),
      .rsp_instant_rate (rsp_instant_rate),
      .rsp_press_count  (rsp_press_count),
      .rsp_average_rate (rsp_average_rate),
      .rsp_elapsed_ms   (rsp_elapsed_ms),
      .rsp_last_report  (rsp_last_report)
   );

endmodule

// File: hdl/fcprm_div.sv
// ----------------------------------------------------------------------------
// Press rate meter divider
// Restoring divider, one quotient bit per cycle, with a preset partial
// remainder so that only the needed quotient bits are developed.
// ----------------------------------------------------------------------------
module fcprm_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [fcprm_pkg::TIME_BITS-1:0]      rem_init,
   input  logic [fcprm_pkg::QUOT_BITS-1:0]      quot_init,
   input  logic [fcprm_pkg::TIME_BITS-1:0]      divisor,
   input  logic [fcprm_pkg::STEP_BITS-1:0]      steps,
   output logic                                 done,
   output logic [fcprm_pkg::QUOT_BITS-1:0]      quotient
);
   import fcprm_pkg::*;

   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [TIME_BITS-1:0] div_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [TIME_BITS:0]   trial;
   logic [TIME_BITS:0]   diff;
   logic                 fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial   = {rem_ff, quot_ff[QUOT_BITS-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = (trial >= {1'b0, div_ff});
      rem_in  = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quot_in = {quot_ff[QUOT_BITS-2:0], fits};
   end

   // Step counter and handshake flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Remainder, quotient and divisor registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= rem_init;
         quot_ff <= quot_init;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: hdl/fcprm_dpath.sv
// ----------------------------------------------------------------------------
// Press rate meter datapath
// Channel state, edge detection, rate arithmetic and the report register.
// ----------------------------------------------------------------------------
module fcprm_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fcprm_pkg::cmd_type                   cmd,
   output fcprm_pkg::stat_type                  stat,
   input  logic                                 req_operation,
   input  logic [fcprm_pkg::TIME_BITS-1:0]      req_time_ms,
   input  logic [fcprm_pkg::CHANNELS-1:0]       req_levels,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fcprm_pkg::CH_BITS-1:0]        rsp_channel,
   output logic [fcprm_pkg::RATE_BITS-1:0]      rsp_instant_rate,
   output logic [fcprm_pkg::COUNT_BITS-1:0]     rsp_press_count,
   output logic [fcprm_pkg::AVG_BITS-1:0]       rsp_average_rate,
   output logic [fcprm_pkg::TIME_BITS-1:0]      rsp_elapsed_ms,
   output logic                                 rsp_last_report
);
   import fcprm_pkg::*;

   // Latched item.
   logic                 op_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [CHANNELS-1:0]  levels_ff;

   // Channel state.
   logic [CHANNELS-1:0]   prev_ff;
   logic [TIME_BITS-1:0]  press_time_ff [CHANNELS];
   logic [RATE_BITS-1:0]  inst_ff       [CHANNELS];
   logic [COUNT_BITS-1:0] count_ff      [CHANNELS];
   logic [AVG_BITS-1:0]   avg_ff        [CHANNELS];
   logic [TIME_BITS-1:0]  wstart_ff;

   // Product of the press count and the scale for one channel.
   logic [PROD_BITS-1:0] prod_ff, prod_in;

   // Report register.
   logic                  rsp_valid_ff;
   logic [CH_BITS-1:0]    rsp_channel_ff;
   logic [RATE_BITS-1:0]  rsp_inst_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic [AVG_BITS-1:0]   rsp_avg_ff;
   logic [TIME_BITS-1:0]  rsp_elapsed_ff;
   logic                  rsp_last_ff;

   // Per-channel terms.
   logic                 is_edge;
   logic [TIME_BITS-1:0] interval;
   logic [TIME_BITS-1:0] span;
   logic                 interval_zero;
   logic                 span_zero;
   logic                 saturate;

   // Divider connections.
   logic [TIME_BITS-1:0] div_rem_init;
   logic [QUOT_BITS-1:0] div_quot_init;
   logic [TIME_BITS-1:0] div_divisor;
   logic [STEP_BITS-1:0] div_steps;
   logic                 div_done;
   logic [QUOT_BITS-1:0] div_quot;

   // Edge, interval and span of the selected channel.
   always_comb begin
      is_edge       = levels_ff[cmd.ch] & ~prev_ff[cmd.ch];
      interval      = now_ff - press_time_ff[cmd.ch];
      span          = now_ff - wstart_ff;
      interval_zero = (interval == '0);
      span_zero     = (span == '0);
      saturate      = (SAT_BITS'(prod_ff) >= {span, {QUOT_BITS{1'b0}}});
      prod_in       = PROD_BITS'(count_ff[cmd.ch]) * PROD_BITS'(SCALE);
   end

   // Divider operands: the scale over the interval, or the product over the span.
   always_comb begin
      if (op_ff == OP_SAMPLE) begin
         div_rem_init  = '0;
         div_quot_init = QUOT_BITS'(SCALE) << (QUOT_BITS - RATE_BITS);
         div_divisor   = interval;
         div_steps     = STEP_BITS'(RATE_BITS);
      end else begin
         div_rem_init  = TIME_BITS'(prod_ff[PROD_BITS-1:QUOT_BITS]);
         div_quot_init = prod_ff[QUOT_BITS-1:0];
         div_divisor   = span;
         div_steps     = STEP_BITS'(QUOT_BITS);
      end
   end

   fcprm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .rem_init  (div_rem_init),
      .quot_init (div_quot_init),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .done      (div_done),
      .quotient  (div_quot)
   );

   // Status to the controller.
   always_comb begin
      stat.need_div = (op_ff == OP_SAMPLE) ? (is_edge && !interval_zero)
                                           : (!span_zero && !saturate);
      stat.div_done = div_done;
      stat.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Item latch and product register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         now_ff    <= req_time_ms;
         levels_ff <= req_levels;
      end
      if (cmd.prep) begin
         prod_ff <= prod_in;
      end
   end

   // Channel state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         wstart_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            press_time_ff[i] <= '0;
            inst_ff[i]       <= '0;
            count_ff[i]      <= '0;
            avg_ff[i]        <= '0;
         end
      end else begin
         if (cmd.commit) begin
            if (op_ff == OP_SAMPLE) begin
               if (is_edge) begin
                  inst_ff[cmd.ch]       <= interval_zero ? SCALE : div_quot[RATE_BITS-1:0];
                  press_time_ff[cmd.ch] <= now_ff;
                  count_ff[cmd.ch]      <= count_ff[cmd.ch] + COUNT_BITS'(1);
               end
            end else begin
               if (span_zero) begin
                  avg_ff[cmd.ch] <= '0;
               end else if (saturate) begin
                  avg_ff[cmd.ch] <= AVG_MAX;
               end else begin
                  avg_ff[cmd.ch] <= div_quot;
               end
               count_ff[cmd.ch] <= '0;
            end
         end
         if (cmd.finish) begin
            if (op_ff == OP_SAMPLE) begin
               prev_ff <= levels_ff;
            end else begin
               wstart_ff <= now_ff;
            end
         end
      end
   end

   // Report valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Report payload.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_channel_ff <= cmd.ch;
         rsp_inst_ff    <= inst_ff[cmd.ch];
         rsp_count_ff   <= count_ff[cmd.ch];
         rsp_avg_ff     <= avg_ff[cmd.ch];
         rsp_elapsed_ff <= span;
         rsp_last_ff    <= cmd.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_instant_rate = rsp_inst_ff;
   assign rsp_press_count  = rsp_count_ff;
   assign rsp_average_rate = rsp_avg_ff;
   assign rsp_elapsed_ms   = rsp_elapsed_ff;
   assign rsp_last_report  = rsp_last_ff;

endmodule

// File: hdl/fcprm_ctrl.sv
// ----------------------------------------------------------------------------
// Press rate meter controller
// Walks the channels once to update them, then once to send the reports.
// ----------------------------------------------------------------------------
`include "four_channel_press_rate_meter_core_defines.svh"

module fcprm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output fcprm_pkg::cmd_type   cmd,
   input  fcprm_pkg::stat_type  stat
);
   import fcprm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_DIV,
      ST_EMIT
   } state_type;

   localparam ch_type LAST_CH = CH_BITS'(CHANNELS - 1);

   state_type state_ff, state_in;
   ch_type    ch_ff, ch_in;
   logic      ch_last;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      ch_last  = (ch_ff == LAST_CH);
      cmd      = '0;
      cmd.ch   = ch_ff;
      cmd.last = ch_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               ch_in    = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.commit = 1'b1;
               if (ch_last) begin
                  cmd.finish = 1'b1;
                  ch_in      = '0;
                  state_in   = ST_EMIT;
               end else begin
                  ch_in    = ch_ff + CH_BITS'(1);
                  state_in = ST_PREP;
               end
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.commit = 1'b1;
               if (ch_last) begin
                  cmd.finish = 1'b1;
                  ch_in      = '0;
                  state_in   = ST_EMIT;
               end else begin
                  ch_in    = ch_ff + CH_BITS'(1);
                  state_in = ST_PREP;
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (ch_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in = ch_ff + CH_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and channel index.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Checks on the command sequence.
   `FCPRM_ASSERT_IMPLY(a_div_needed, clock, reset, cmd.div_start, stat.need_div)
   `FCPRM_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, stat.out_free)
   `FCPRM_ASSERT_IMPLY(a_done_in_div, clock, reset, stat.div_done, state_ff == ST_DIV)
   `FCPRM_ASSERT_NEXT(a_last_idle, clock, reset, cmd.emit && cmd.last, state_ff == ST_IDLE)

endmodule
